// ===== hw/rtl/fpa_pkg.sv =====
package fpa_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned PROD_W         = 2 * DATA_W;
  localparam int unsigned WIDE_W         = 66;
  localparam int unsigned QUOT_BITS      = 34;
  localparam int unsigned DEF_FRAC_BITS  = 8;
  localparam int unsigned DEF_VALUE_W    = 32;
  localparam int unsigned DEF_QUEUE_DEPTH = 4;

  localparam logic [3:0] ACT_ADD      = 4'd0;
  localparam logic [3:0] ACT_SUB      = 4'd1;
  localparam logic [3:0] ACT_MUL      = 4'd2;
  localparam logic [3:0] ACT_DIV      = 4'd3;
  localparam logic [3:0] ACT_MIN      = 4'd4;
  localparam logic [3:0] ACT_MAX      = 4'd5;
  localparam logic [3:0] ACT_INC      = 4'd6;
  localparam logic [3:0] ACT_DEC      = 4'd7;
  localparam logic [3:0] ACT_TO_INT   = 4'd8;
  localparam logic [3:0] ACT_FROM_INT = 4'd9;

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_MUL  = 2'd1;
  localparam logic [1:0] KIND_DIV  = 2'd2;

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] val;
  } sat_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic              neg;
    logic [DATA_W-1:0] res;
    logic              less;
    logic              equal;
    logic              greater;
    logic              ovf;
    logic              dz;
  } item_t;

  typedef struct packed {
    logic                 valid;
    logic [1:0]           kind;
    logic                 neg;
    logic [DATA_W-1:0]    res;
    logic                 less;
    logic                 equal;
    logic                 greater;
    logic                 ovf;
    logic                 dz;
    logic                 huge;
    logic [PROD_W-1:0]    prod;
    logic [DATA_W-1:0]    den;
    logic [DATA_W-1:0]    rem;
    logic [QUOT_BITS-1:0] qt;
    logic [QUOT_BITS-1:0] nlo;
  } stage_t;

  function automatic sat_t saturate(input logic signed [WIDE_W-1:0] v,
                                    input int unsigned w);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    int unsigned              sw;
    sat_t                     s;
    sw = (w > DATA_W) ? DATA_W : w;
    hi = (66'sd1 <<< (sw - 1)) - 66'sd1;
    lo = -hi - 66'sd1;
    if (v > hi) begin
      s.ovf = 1'b1;
      s.val = hi[DATA_W-1:0];
    end else if (v < lo) begin
      s.ovf = 1'b1;
      s.val = lo[DATA_W-1:0];
    end else begin
      s.ovf = 1'b0;
      s.val = v[DATA_W-1:0];
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/fpa_front.sv =====
module fpa_front #(
  parameter int unsigned FRAC_BITS   = fpa_pkg::DEF_FRAC_BITS,
  parameter int unsigned VALUE_WIDTH = fpa_pkg::DEF_VALUE_W
) (
  input  logic [3:0]         action,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output fpa_pkg::item_t     item
);
  import fpa_pkg::*;

  logic signed [WIDE_W-1:0] a_x;
  logic signed [WIDE_W-1:0] b_x;
  logic signed [WIDE_W-1:0] big;
  logic signed [WIDE_W-1:0] v;
  sat_t                     s;

  assign a_x = {{(WIDE_W-DATA_W){operand_a[DATA_W-1]}}, operand_a};
  assign b_x = {{(WIDE_W-DATA_W){operand_b[DATA_W-1]}}, operand_b};
  assign big = 66'sd1 <<< 40;

  always_comb begin
    item.kind    = KIND_DONE;
    item.mag_a   = operand_a[DATA_W-1] ? (32'd0 - operand_a) : operand_a;
    item.mag_b   = operand_b[DATA_W-1] ? (32'd0 - operand_b) : operand_b;
    item.neg     = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
    item.less    = operand_a < operand_b;
    item.equal   = operand_a == operand_b;
    item.greater = operand_a > operand_b;
    item.dz      = 1'b0;
    v            = '0;
    case (action)
      ACT_ADD:      v = a_x + b_x;
      ACT_SUB:      v = a_x - b_x;
      ACT_MUL:      item.kind = KIND_MUL;
      ACT_DIV: begin
        if (operand_b == 32'sd0) begin
          item.dz = 1'b1;
          v = (operand_a > 32'sd0) ? big : ((operand_a < 32'sd0) ? -big : '0);
        end else begin
          item.kind = KIND_DIV;
        end
      end
      ACT_MIN:      v = (operand_a <= operand_b) ? a_x : b_x;
      ACT_MAX:      v = (operand_a >= operand_b) ? a_x : b_x;
      ACT_INC:      v = a_x + 66'sd1;
      ACT_DEC:      v = a_x - 66'sd1;
      ACT_TO_INT:   v = a_x >>> FRAC_BITS;
      ACT_FROM_INT: v = a_x <<< FRAC_BITS;
      default:      v = '0;
    endcase
    s        = saturate(v, VALUE_WIDTH);
    item.res = s.val;
    item.ovf = s.ovf & ~item.dz;
  end

endmodule

// ===== hw/rtl/fpa_queue.sv =====
module fpa_queue #(
  parameter int unsigned DEPTH = fpa_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  fpa_pkg::item_t wr_data,
  input  logic           rd_en,
  output fpa_pkg::item_t rd_data,
  output logic           full,
  output logic           empty
);
  import fpa_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t              mem_r [DEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_wr;
  logic               do_rd;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/fpa_back.sv =====
module fpa_back #(
  parameter int unsigned FRAC_BITS   = fpa_pkg::DEF_FRAC_BITS,
  parameter int unsigned VALUE_WIDTH = fpa_pkg::DEF_VALUE_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fpa_pkg::item_t     q_data,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] result,
  output logic               less,
  output logic               equal,
  output logic               greater,
  output logic               overflow,
  output logic               div_zero
);
  import fpa_pkg::*;

  localparam int unsigned LAST = QUOT_BITS + 1;
  localparam int unsigned NSTG = LAST + 1;
  localparam int unsigned CW   = WIDE_W + FRAC_BITS;

  stage_t            stg_r   [NSTG];
  stage_t            stg_nxt [NSTG];
  logic              adv;
  logic [CW-1:0]     n2w;
  logic [CW-1:0]     dlim;

  function automatic stage_t mul_fin(input stage_t si);
    stage_t                   so;
    logic [PROD_W-1:0]        r;
    logic signed [WIDE_W-1:0] rv;
    sat_t                     s;
    so = si;
    r  = (si.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    rv = {2'b00, r};
    s  = saturate(si.neg ? -rv : rv, VALUE_WIDTH);
    if (si.kind == KIND_MUL) begin
      so.kind = KIND_DONE;
      so.res  = s.val;
      so.ovf  = s.ovf;
    end
    return so;
  endfunction

  function automatic stage_t div_step(input stage_t si);
    stage_t      so;
    logic [32:0] trial;
    logic        ge;
    so    = si;
    trial = {si.rem, si.nlo[QUOT_BITS-1]};
    ge    = trial >= {1'b0, si.den};
    if (si.kind == KIND_DIV) begin
      so.rem = ge ? 32'(trial - {1'b0, si.den}) : trial[31:0];
      so.qt  = {si.qt[QUOT_BITS-2:0], ge};
      so.nlo = {si.nlo[QUOT_BITS-2:0], 1'b0};
    end
    return so;
  endfunction

  function automatic stage_t div_fin(input stage_t si);
    stage_t                   so;
    logic [QUOT_BITS:0]       q;
    logic signed [WIDE_W-1:0] qv;
    logic signed [WIDE_W-1:0] v;
    sat_t                     s;
    so = si;
    q  = ({1'b0, si.qt} + 1'b1) >> 1;
    qv = {{(WIDE_W-QUOT_BITS-1){1'b0}}, q};
    if (si.huge) begin
      v = si.neg ? -(66'sd1 <<< 40) : (66'sd1 <<< 40);
    end else begin
      v = si.neg ? -qv : qv;
    end
    s = saturate(v, VALUE_WIDTH);
    if (si.kind == KIND_DIV) begin
      so.kind = KIND_DONE;
      so.res  = s.val;
      so.ovf  = s.ovf;
    end
    return so;
  endfunction

  assign adv   = ~stg_r[LAST].valid | pop;
  assign q_pop = adv & ~q_empty;

  assign n2w  = CW'(q_data.mag_a) << (FRAC_BITS + 1);
  assign dlim = CW'(q_data.mag_b) << QUOT_BITS;

  always_comb begin
    stg_nxt[0].valid   = q_pop;
    stg_nxt[0].kind    = q_data.kind;
    stg_nxt[0].neg     = q_data.neg;
    stg_nxt[0].res     = q_data.res;
    stg_nxt[0].less    = q_data.less;
    stg_nxt[0].equal   = q_data.equal;
    stg_nxt[0].greater = q_data.greater;
    stg_nxt[0].ovf     = q_data.ovf;
    stg_nxt[0].dz      = q_data.dz;
    stg_nxt[0].huge    = n2w >= dlim;
    stg_nxt[0].prod    = PROD_W'(q_data.mag_a) * PROD_W'(q_data.mag_b);
    stg_nxt[0].den     = q_data.mag_b;
    stg_nxt[0].rem     = n2w[QUOT_BITS +: DATA_W];
    stg_nxt[0].qt      = '0;
    stg_nxt[0].nlo     = n2w[QUOT_BITS-1:0];
  end

  for (genvar k = 1; k <= QUOT_BITS; k++) begin : g_step
    always_comb begin
      if (k == 1) begin
        stg_nxt[k] = div_step(mul_fin(stg_r[k-1]));
      end else begin
        stg_nxt[k] = div_step(stg_r[k-1]);
      end
    end
  end

  assign stg_nxt[LAST] = div_fin(stg_r[LAST-1]);

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (!rst_n) begin
        stg_r[k].valid <= 1'b0;
      end else if (adv) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign empty    = ~stg_r[LAST].valid;
  assign result   = stg_r[LAST].res;
  assign less     = stg_r[LAST].less;
  assign equal    = stg_r[LAST].equal;
  assign greater  = stg_r[LAST].greater;
  assign overflow = stg_r[LAST].ovf;
  assign div_zero = stg_r[LAST].dz;

endmodule

// ===== hw/rtl/fixed_point_alu_top.sv =====
// A pushed transaction is written into the queue, then passes through the back pipeline stages to the result ports.
// Throughput: one transaction per cycle; the back pipeline advances as a whole
// and holds whenever its final stage is occupied and pop is low.
// The depth is set by the divider: one restoring quotient bit per stage, 34 stages.
// Reset: synchronous, active low; clears the queue and all stage valid bits.
module fixed_point_alu_top #(
  parameter int unsigned FRAC_BITS   = fpa_pkg::DEF_FRAC_BITS,
  parameter int unsigned VALUE_WIDTH = fpa_pkg::DEF_VALUE_W,
  parameter int unsigned QUEUE_DEPTH = fpa_pkg::DEF_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [3:0]         in_action,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_result,
  output logic               out_less,
  output logic               out_equal,
  output logic               out_greater,
  output logic               out_overflow,
  output logic               out_div_zero
);
  import fpa_pkg::*;

  item_t front_item;
  item_t q_data;
  logic  q_empty;
  logic  q_pop;

  fpa_front #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .action    (in_action),
    .operand_a (in_operand_a),
    .operand_b (in_operand_b),
    .item      (front_item)
  );

  fpa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (front_item),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  fpa_back #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_data),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .result   (out_result),
    .less     (out_less),
    .equal    (out_equal),
    .greater  (out_greater),
    .overflow (out_overflow),
    .div_zero (out_div_zero)
  );

endmodule

// ===== hw/rtl/fpa_checker.sv =====
module fpa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic signed [31:0] out_result,
  input logic               out_less,
  input logic               out_equal,
  input logic               out_greater,
  input logic               out_overflow,
  input logic               out_div_zero
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result side not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input side full after reset");

  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> $onehot({out_less, out_equal, out_greater}))
    else $error("compare flags not exclusive");

  a_dz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_div_zero) |-> !out_overflow)
    else $error("div_zero with overflow");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_result)))
    else $error("waiting transaction dropped or changed");

endmodule

bind fixed_point_alu_top fpa_checker u_fpa_checker (.*);
